/* sv/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared constants and helpers for the rational activation unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int MAX_NUM_DEGREE_DEF = 7;
    localparam int MAX_DEN_TERMS_DEF  = 8;
    localparam int DATA_WIDTH_DEF     = 16;
    localparam int FRAC_BITS_DEF      = 12;

    // Accumulator width; numerator and denominator arithmetic wraps here, powers are held narrower.
    localparam int ACC_W    = 64;
    localparam int WORD_W   = 16;
    localparam int NWORDS   = 8;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 64;
    localparam int EPS_W    = 12;

    localparam logic [CFG_AW-1:0] REG_NUM_DEGREE  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_DEN_TERMS   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_NUM_LOW     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_NUM_HIGH    = 3'd3;
    localparam logic [CFG_AW-1:0] REG_DEN_LOW     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_DEN_HIGH    = 3'd5;
    localparam logic [CFG_AW-1:0] REG_STAB_OFFSET = 3'd6;

    // Coefficient word number idx out of a pair of packed registers; zero past the last word.
    function automatic logic [WORD_W-1:0] coef_word(input logic [CFG_DW-1:0] lo,
                                                    input logic [CFG_DW-1:0] hi,
                                                    input int idx);
        logic [CFG_DW-1:0] w;
        w = '0;
        if (idx >= 0 && idx < NWORDS) begin
            w = ((idx < 4) ? lo : hi) >> (WORD_W * (idx % 4));
        end
        return w[WORD_W-1:0];
    endfunction

endpackage

/* sv/rau_cell.sv */
// ----------------------------------------------------------------------------
// rau_cell
// One term of the rational function: multiplies the running power by both
// coefficients and by the sample, then accumulates and rounds the power.
// ----------------------------------------------------------------------------
module rau_cell #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rau_pkg::FRAC_BITS_DEF,
    parameter int PW_W       = rau_pkg::ACC_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_valid,
    input  logic [DATA_WIDTH-1:0]       i_x,
    input  logic [PW_W-1:0]             i_pw,
    input  logic [rau_pkg::ACC_W-1:0]   i_num,
    input  logic [rau_pkg::ACC_W-1:0]   i_den,
    input  logic [rau_pkg::WORD_W-1:0]  i_p_coef,
    input  logic [rau_pkg::WORD_W-1:0]  i_q_coef,
    input  logic                        i_num_en,
    input  logic                        i_den_en,
    output logic                        o_valid,
    output logic [DATA_WIDTH-1:0]       o_x,
    output logic [PW_W-1:0]             o_pw,
    output logic [rau_pkg::ACC_W-1:0]   o_num,
    output logic [rau_pkg::ACC_W-1:0]   o_den
);
    import rau_pkg::*;

    logic                 r_v1;
    logic [DATA_WIDTH-1:0] r_x1;
    logic [ACC_W-1:0]     r_pnum, r_pden, r_ppw, r_num1, r_den1;
    logic                 r_v2;
    logic [DATA_WIDTH-1:0] r_x2;
    logic [PW_W-1:0]      r_pw2;
    logic [ACC_W-1:0]     r_num2, r_den2;

    // The power never needs more than PW_W bits, so the products stay narrow.
    logic signed [PW_W-1:0]            pw_s;
    logic signed [PW_W+WORD_W-1:0]     pnum_full, pden_full;
    logic signed [PW_W+DATA_WIDTH-1:0] ppw_full;
    logic [PW_W-1:0]      n_pw;
    logic [ACC_W-1:0]     n_num, n_den, pden_mag;

    assign pw_s      = $signed(i_pw);
    assign pnum_full = pw_s * $signed(i_p_coef);
    assign pden_full = pw_s * $signed(i_q_coef);
    assign ppw_full  = pw_s * $signed(i_x);

    assign pden_mag = r_pden[ACC_W-1] ? (ACC_W'(0) - r_pden) : r_pden;
    assign n_num    = r_num1 + r_pnum;
    assign n_den    = r_den1 + pden_mag;
    assign n_pw     = PW_W'($signed(r_ppw + (ACC_W'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_x1   <= i_x;
            r_pnum <= i_num_en ? ACC_W'(pnum_full) : '0;
            r_pden <= i_den_en ? ACC_W'(pden_full) : '0;
            r_ppw  <= ACC_W'(ppw_full);
            r_num1 <= i_num;
            r_den1 <= i_den;
            r_x2   <= r_x1;
            r_pw2  <= n_pw;
            r_num2 <= n_num;
            r_den2 <= n_den;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x2;
    assign o_pw    = r_pw2;
    assign o_num   = r_num2;
    assign o_den   = r_den2;
endmodule

/* sv/rau_div_step.sv */
// ----------------------------------------------------------------------------
// rau_div_step
// One restoring division step: resolves quotient bit STEP.
// ----------------------------------------------------------------------------
module rau_div_step #(
    parameter int NW   = 65,
    parameter int DFW  = 52,
    parameter int QB   = 17,
    parameter int STEP = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  logic [NW-1:0]  i_rem,
    input  logic [DFW-1:0] i_d,
    input  logic [QB-1:0]  i_q,
    input  logic           i_neg,
    input  logic           i_ovf,
    output logic           o_valid,
    output logic [NW-1:0]  o_rem,
    output logic [DFW-1:0] o_d,
    output logic [QB-1:0]  o_q,
    output logic           o_neg,
    output logic           o_ovf
);
    localparam int CW = NW + QB + 1;

    logic [CW-1:0] d_sh, rem_w;
    logic          take;

    assign d_sh  = CW'(i_d) << STEP;
    assign rem_w = CW'(i_rem);
    assign take  = rem_w >= d_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_adv) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            o_rem <= take ? NW'(rem_w - d_sh) : i_rem;
            o_d   <= i_d;
            o_q   <= i_q | (take ? (QB'(1) << STEP) : QB'(0));
            o_neg <= i_neg;
            o_ovf <= i_ovf;
        end
    end
endmodule

/* sv/rational_activation_unit_core.sv */
// ----------------------------------------------------------------------------
// rational_activation_unit_core
// Elementwise rational activation y = P(x) / (1 + sum |q_j x^j| + eps).
// ----------------------------------------------------------------------------
// Samples enter on the input channel (i_in_valid / o_in_ready, i_sample) and
// results leave on the output channel (o_out_valid / i_out_ready,
// o_activation, o_saturated), one result per sample, in order.
// A row of term cells, one per power of x, forms the powers and accumulates
// numerator and denominator. A row of division cells then produces one
// quotient bit each, after a registered overflow check, and an output
// register holds the result. One sample is taken every cycle while the
// output is not stalled.
// The whole pipeline advances together; when the receiver holds i_out_ready
// low with a result waiting, the pipeline freezes and o_in_ready drops.
// Empty pipeline slots do not fill while a result waits, only once it moves.
// Reset clears all valid bits and the configuration registers to zero.
// Configuration is written through i_cfg_we / i_cfg_addr / i_cfg_data and
// must only change while no item is in flight.
// ----------------------------------------------------------------------------
module rational_activation_unit_core #(
    parameter int MAX_NUM_DEGREE = rau_pkg::MAX_NUM_DEGREE_DEF,
    parameter int MAX_DEN_TERMS  = rau_pkg::MAX_DEN_TERMS_DEF,
    parameter int DATA_WIDTH     = rau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS      = rau_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rau_pkg::CFG_AW-1:0]    i_cfg_addr,
    input  logic [rau_pkg::CFG_DW-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_sample,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [DATA_WIDTH-1:0]  o_activation,
    output logic                          o_saturated
);
    import rau_pkg::*;

    localparam int NC  = ((MAX_NUM_DEGREE > MAX_DEN_TERMS) ? MAX_NUM_DEGREE : MAX_DEN_TERMS) + 1;
    localparam int QB  = DATA_WIDTH + 1;
    localparam int NW  = ACC_W + 1;
    localparam int DFW = ACC_W - FRAC_BITS;
    localparam int CW  = NW + QB + 1;

    // Each power grows by at most the integer bits of x, so it fits in PW_W bits.
    localparam int XI_W    = (DATA_WIDTH - 1 > FRAC_BITS) ? (DATA_WIDTH - 1 - FRAC_BITS) : 0;
    localparam int PW_BITS = XI_W * (NC - 1) + FRAC_BITS + 2;
    localparam int PW_W    = (PW_BITS < ACC_W) ? PW_BITS : ACC_W;

    logic [2:0]        r_num_degree;
    logic [3:0]        r_den_terms;
    logic [CFG_DW-1:0] r_num_lo, r_num_hi, r_den_lo, r_den_hi;
    logic [EPS_W-1:0]  r_eps;

    logic adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_degree <= '0;
            r_den_terms  <= '0;
            r_num_lo     <= '0;
            r_num_hi     <= '0;
            r_den_lo     <= '0;
            r_den_hi     <= '0;
            r_eps        <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_NUM_DEGREE:  r_num_degree <= i_cfg_data[2:0];
                REG_DEN_TERMS:   r_den_terms  <= i_cfg_data[3:0];
                REG_NUM_LOW:     r_num_lo     <= i_cfg_data;
                REG_NUM_HIGH:    r_num_hi     <= i_cfg_data;
                REG_DEN_LOW:     r_den_lo     <= i_cfg_data;
                REG_DEN_HIGH:    r_den_hi     <= i_cfg_data;
                REG_STAB_OFFSET: r_eps        <= i_cfg_data[EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Term cell chain.
    logic                  c_valid [NC+1];
    logic [DATA_WIDTH-1:0] c_x     [NC+1];
    logic [PW_W-1:0]       c_pw    [NC+1];
    logic [ACC_W-1:0]      c_num   [NC+1];
    logic [ACC_W-1:0]      c_den   [NC+1];

    assign c_valid[0] = i_in_valid & o_in_ready;
    assign c_x[0]     = i_sample;
    assign c_pw[0]    = PW_W'(1) << FRAC_BITS;
    assign c_num[0]   = '0;
    assign c_den[0]   = (ACC_W'(1) << (2 * FRAC_BITS)) + (ACC_W'(r_eps) << FRAC_BITS);

    for (genvar j = 0; j < NC; j++) begin : g_cell
        logic num_en, den_en;
        assign num_en = (j <= int'(r_num_degree)) && (j <= MAX_NUM_DEGREE);
        assign den_en = (j >= 1) && (j <= int'(r_den_terms)) && (j <= MAX_DEN_TERMS);

        rau_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FRAC_BITS  (FRAC_BITS),
            .PW_W       (PW_W)
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_adv    (adv),
            .i_valid  (c_valid[j]),
            .i_x      (c_x[j]),
            .i_pw     (c_pw[j]),
            .i_num    (c_num[j]),
            .i_den    (c_den[j]),
            .i_p_coef (coef_word(r_num_lo, r_num_hi, j)),
            .i_q_coef (coef_word(r_den_lo, r_den_hi, j - 1)),
            .i_num_en (num_en),
            .i_den_en (den_en),
            .o_valid  (c_valid[j+1]),
            .o_x      (c_x[j+1]),
            .o_pw     (c_pw[j+1]),
            .o_num    (c_num[j+1]),
            .o_den    (c_den[j+1])
        );
    end

    // Overflow check and dividend setup.
    logic [DFW-1:0] df_raw, df;
    logic [ACC_W-1:0] num_f, mag;
    logic [NW-1:0]  dividend;
    logic           ovf;

    assign num_f    = c_num[NC];
    assign df_raw   = DFW'(c_den[NC] >> FRAC_BITS);
    assign df       = (df_raw == '0) ? DFW'(1) : df_raw;
    assign mag      = num_f[ACC_W-1] ? (ACC_W'(0) - num_f) : num_f;
    assign dividend = NW'(mag) + NW'(df >> 1);
    assign ovf      = CW'(dividend) >= (CW'(df) << QB);

    logic           d_valid [QB+1];
    logic [NW-1:0]  d_rem   [QB+1];
    logic [DFW-1:0] d_d     [QB+1];
    logic [QB-1:0]  d_q     [QB+1];
    logic           d_neg   [QB+1];
    logic           d_ovf   [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            d_valid[0] <= 1'b0;
        end else if (adv) begin
            d_valid[0] <= c_valid[NC];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            d_rem[0] <= ovf ? '0 : dividend;
            d_d[0]   <= df;
            d_q[0]   <= '0;
            d_neg[0] <= num_f[ACC_W-1];
            d_ovf[0] <= ovf;
        end
    end

    for (genvar k = 0; k < QB; k++) begin : g_div
        rau_div_step #(
            .NW   (NW),
            .DFW  (DFW),
            .QB   (QB),
            .STEP (QB - 1 - k)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (d_valid[k]),
            .i_rem   (d_rem[k]),
            .i_d     (d_d[k]),
            .i_q     (d_q[k]),
            .i_neg   (d_neg[k]),
            .i_ovf   (d_ovf[k]),
            .o_valid (d_valid[k+1]),
            .o_rem   (d_rem[k+1]),
            .o_d     (d_d[k+1]),
            .o_q     (d_q[k+1]),
            .o_neg   (d_neg[k+1]),
            .o_ovf   (d_ovf[k+1])
        );
    end

    // Saturation and sign.
    localparam logic [QB-1:0] POS_MAX = QB'((1 << (DATA_WIDTH - 1)) - 1);
    localparam logic [QB-1:0] NEG_MAX = QB'(1 << (DATA_WIDTH - 1));

    logic [QB-1:0] q_fin, q_clip;
    logic          sat;

    assign q_fin = d_q[QB];
    always_comb begin
        sat    = 1'b0;
        q_clip = q_fin;
        if (d_neg[QB]) begin
            if (d_ovf[QB] || q_fin > NEG_MAX) begin
                sat    = 1'b1;
                q_clip = NEG_MAX;
            end
        end else begin
            if (d_ovf[QB] || q_fin > POS_MAX) begin
                sat    = 1'b1;
                q_clip = POS_MAX;
            end
        end
    end

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= d_valid[QB];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_activation <= DATA_WIDTH'(d_neg[QB] ? (QB'(0) - q_clip) : q_clip);
            o_saturated  <= sat;
        end
    end
endmodule

/* sv/rau_checker.sv */
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational activation unit.
// ----------------------------------------------------------------------------
module rau_checker #(
    parameter int DATA_WIDTH = rau_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [DATA_WIDTH-1:0] o_activation,
    input logic                  o_saturated
);
    localparam logic [DATA_WIDTH-1:0] ACT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] ACT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_ready) |=> i_in_valid)
        else $error("input item withdrawn before it was taken");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |-> (o_activation == ACT_MAX || o_activation == ACT_MIN))
        else $error("saturated item not at range limit");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_activation)
                                          && $stable(o_saturated)))
        else $error("stalled output item changed");
endmodule

bind rational_activation_unit_core rau_checker #(.DATA_WIDTH(DATA_WIDTH)) u_rau_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_activation (o_activation),
    .o_saturated  (o_saturated)
);
